@@ hdl/gregorian_date_check_weekday_core_macros.svh @@
// Assertion macros for the date check core.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef GREGORIAN_DATE_CHECK_WEEKDAY_CORE_MACROS_SVH
`define GREGORIAN_DATE_CHECK_WEEKDAY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GDCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GDCW_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) else $error(msg);
`else
`define GDCW_ASSERT(lbl, prop, msg)
`define GDCW_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ hdl/gdcw_pkg.sv @@
package gdcw_pkg;

    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_PRE_REFORM = 3'd1;
    localparam logic [2:0] ERR_MONTH      = 3'd2;
    localparam logic [2:0] ERR_DAY_RANGE  = 3'd3;
    localparam logic [2:0] ERR_DAY_MONTH  = 3'd4;

    localparam logic [13:0] REFORM_YEAR  = 14'd1582;
    localparam logic [3:0]  REFORM_MONTH = 4'd10;
    localparam logic [5:0]  REFORM_DAY   = 6'd15;
    // absolute day number of 15 Oct 1582
    localparam logic [22:0] REFORM_DAYNUM = 23'd578100;

    // p / 100 == (p * RECIP_100) >> RECIP_SHIFT, exact for 14-bit p
    localparam logic [27:0] RECIP_100   = 28'd10486;
    localparam int          RECIP_SHIFT = 20;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date;

    typedef struct packed {
        logic [2:0]  err;
        logic        leap;
        logic [3:0]  month;
        logic [5:0]  day;
        logic [22:0] base;
    } t_chk;

    typedef struct packed {
        logic [2:0]  err;
        logic        leap;
        logic [22:0] days;
    } t_res;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days before month index mi (0 = January)
    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mi);
        logic [8:0] n;
        unique case (mi)
            4'd0:    n = 9'd0;
            4'd1:    n = 9'd31;
            4'd2:    n = 9'd59;
            4'd3:    n = 9'd90;
            4'd4:    n = 9'd120;
            4'd5:    n = 9'd151;
            4'd6:    n = 9'd181;
            4'd7:    n = 9'd212;
            4'd8:    n = 9'd243;
            4'd9:    n = 9'd273;
            4'd10:   n = 9'd304;
            4'd11:   n = 9'd334;
            4'd12:   n = 9'd365;
            default: n = 9'd0;
        endcase
        if (leap && mi >= 4'd2 && mi <= 4'd12) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

@@ hdl/gdcw_year_stage.sv @@
module gdcw_year_stage
    import gdcw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_date i_date,
    output logic  o_valid,
    input  logic  i_ready,
    output t_chk  o_chk
);

    // stage A: register date, start p / 100
    logic        r_va;
    t_date       r_date;
    logic [13:0] r_p;
    logic [27:0] r_prod;
    logic        ready_a;
    logic        ready_b;
    logic [13:0] p;

    // stage B: checks and year base
    logic        r_vb;
    t_chk        r_chk;
    t_chk        n_chk;
    logic [7:0]  q;
    logic [13:0] rem;
    logic        leap;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;
    assign p       = i_date.year - 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (ready_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_date <= i_date;
            r_p    <= p;
            r_prod <= 28'(p) * RECIP_100;
        end
    end

    always_comb begin
        q   = r_prod[RECIP_SHIFT +: 8];
        rem = r_p - 14'(q) * 14'd100;
        // y % 100 == 0 iff (y-1) % 100 == 99; year 0 wraps and still comes out leap
        leap = (r_date.year[1:0] == 2'd0) && ((rem != 14'd99) || (q[1:0] == 2'd3));

        n_chk.leap  = leap;
        n_chk.month = r_date.month;
        n_chk.day   = r_date.day;
        n_chk.base  = 23'(r_date.year) * 23'd365 + 23'(r_p[13:2]) - 23'(q) + 23'(q[7:2]);

        priority if (r_date.year < REFORM_YEAR
                     || (r_date.year == REFORM_YEAR && r_date.month < REFORM_MONTH)
                     || (r_date.year == REFORM_YEAR && r_date.month <= REFORM_MONTH
                         && r_date.day < REFORM_DAY)) begin
            n_chk.err = ERR_PRE_REFORM;
        end else if (r_date.month == 4'd0 || r_date.month >= 4'd13) begin
            n_chk.err = ERR_MONTH;
        end else if (r_date.day == 6'd0 || r_date.day >= 6'd32) begin
            n_chk.err = ERR_DAY_RANGE;
        end else if (6'(month_len(leap, r_date.month)) < r_date.day) begin
            n_chk.err = ERR_DAY_MONTH;
        end else begin
            n_chk.err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ready_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_va) begin
            r_chk <= n_chk;
        end
    end

    assign o_valid = r_vb;
    assign o_chk   = r_chk;

endmodule

@@ hdl/gdcw_days_stage.sv @@
module gdcw_days_stage
    import gdcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_chk i_chk,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic        r_v;
    t_res        r_res;
    t_res        n_res;
    logic        ready;
    logic [22:0] sum;

    assign ready   = !r_v || i_ready;
    assign o_ready = ready;

    always_comb begin
        sum = i_chk.base + 23'(days_before(i_chk.leap, 4'(i_chk.month - 4'd1)))
            + 23'(i_chk.day) - 23'd1 - REFORM_DAYNUM;
        n_res.err  = i_chk.err;
        n_res.leap = i_chk.leap;
        n_res.days = (i_chk.err == ERR_OK) ? sum : 23'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_res;

endmodule

@@ hdl/gdcw_mod7_stage.sv @@
module gdcw_mod7_stage
    import gdcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_res       i_res,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res,
    output logic [2:0] o_weekday
);

    logic        r_v;
    t_res        r_res;
    logic [2:0]  r_weekday;
    logic [2:0]  n_weekday;
    logic        ready;
    logic [23:0] wide;
    logic [5:0]  dsum;
    logic [3:0]  fold1;
    logic [2:0]  fold2;

    assign ready   = !r_v || i_ready;
    assign o_ready = ready;

    // 8 == 1 mod 7: add the octal digits, then fold twice
    always_comb begin
        wide = {1'b0, i_res.days};
        dsum = 6'd0;
        for (int k = 0; k < 8; k++) begin
            dsum = dsum + 6'(wide[3*k +: 3]);
        end
        fold1     = 4'(dsum[5:3]) + 4'(dsum[2:0]);
        fold2     = 3'(4'(fold1[3]) + 4'(fold1[2:0]));
        n_weekday = (fold2 == 3'd7) ? 3'd0 : fold2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_res     <= i_res;
            r_weekday <= n_weekday;
        end
    end

    assign o_valid   = r_v;
    assign o_res     = r_res;
    assign o_weekday = r_weekday;

endmodule

@@ hdl/gregorian_date_check_weekday_core.sv @@
// Gregorian date check and weekday.
// Input channel: i_valid / o_stall with i_day_of_month, i_month_number, i_year_number.
// A transaction is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_error_code, o_is_leap,
// o_days_since_reform and o_weekday; one result per input, in order.
// Error codes: 0 ok, 1 before 15 Oct 1582, 2 bad month, 3 day outside 1..31,
// 4 day beyond month length. On error the day count and weekday are 0.
// Weekday 0 is Friday.
// Between an input transaction and o_valid lie the four register stages
// (input/divide-by-100 product, checks and year base, day count, mod 7).
// Throughput: one transaction per cycle while i_stall is low.
// Each stage holds only while it is full and the one after it holds, so
// bubbles close up; o_stall rises only when all four stages are full and
// i_stall is high. A stalled result holds its value.
// Reset (synchronous, i_rst_n low) empties the pipeline; in-flight
// transactions are dropped.
`include "gregorian_date_check_weekday_core_macros.svh"

module gregorian_date_check_weekday_core
    import gdcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_day_of_month,
    input  logic [3:0]  i_month_number,
    input  logic [13:0] i_year_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_error_code,
    output logic        o_is_leap,
    output logic [22:0] o_days_since_reform,
    output logic [2:0]  o_weekday
);

    t_date date;
    t_chk  chk;
    t_res  days_res;
    t_res  out_res;
    logic  year_ready;
    logic  chk_valid;
    logic  days_ready;
    logic  days_valid;
    logic  mod7_ready;

    assign date.day   = i_day_of_month;
    assign date.month = i_month_number;
    assign date.year  = i_year_number;

    gdcw_year_stage u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (year_ready),
        .i_date  (date),
        .o_valid (chk_valid),
        .i_ready (days_ready),
        .o_chk   (chk)
    );

    gdcw_days_stage u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chk_valid),
        .o_ready (days_ready),
        .i_chk   (chk),
        .o_valid (days_valid),
        .i_ready (mod7_ready),
        .o_res   (days_res)
    );

    gdcw_mod7_stage u_mod7 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (days_valid),
        .o_ready   (mod7_ready),
        .i_res     (days_res),
        .o_valid   (o_valid),
        .i_ready   (!i_stall),
        .o_res     (out_res),
        .o_weekday (o_weekday)
    );

    assign o_stall             = !year_ready;
    assign o_error_code        = out_res.err;
    assign o_is_leap           = out_res.leap;
    assign o_days_since_reform = out_res.days;

    `GDCW_ASSERT(a_err_zeroes, (o_valid && o_error_code != ERR_OK) |-> (o_days_since_reform == 23'd0 && o_weekday == 3'd0), "invalid date with non-zero count")
    `GDCW_ASSERT(a_stall_full, o_stall |-> (o_valid && i_stall && chk_valid && days_valid), "input stalled with room in pipeline")
    `GDCW_ASSERT(a_err_range, o_valid |-> (o_error_code <= ERR_DAY_MONTH && o_weekday != 3'd7), "result code out of range")
    `GDCW_ASSERT_NEXT(a_drain, (o_valid && !i_stall && !days_valid), !o_valid, "result repeated after hand-over")

endmodule
